// File: sv/pcm_to_dac_pingpong_player_unit_defines.svh
// Assertion macros shared by the player RTL
`ifndef PCM_TO_DAC_PINGPONG_PLAYER_UNIT_DEFINES_SVH
`define PCM_TO_DAC_PINGPONG_PLAYER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define PDP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define PDP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/pcmdac_pkg.sv
// Shared constants, codes, types and helpers of the PCM to DAC player
package pcmdac_pkg;

    localparam int BLOCK_SAMPLES = 130;
    localparam int SWITCH_POINT  = 67;
    localparam int MAX_LEVEL     = 10;

    localparam int SAMPLE_W    = 16;
    localparam int CODE_W      = 10;
    localparam int DROP_BITS   = 6;
    localparam int AMP_W       = SAMPLE_W - DROP_BITS;
    localparam int VOL_W       = 4;
    localparam int DIV_W       = 4;
    localparam int DIV_CNT_W   = $clog2(AMP_W);
    localparam int REQ_W       = 2;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 10;
    localparam int IDX_W       = $clog2(BLOCK_SAMPLES + 1);
    localparam int STORE_DEPTH = 2 * BLOCK_SAMPLES;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    localparam logic [CODE_W-1:0] DAC_MAX = '1;

    // request codes
    localparam logic [REQ_W-1:0] REQ_SAMPLE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_TICK   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_STOP   = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_VOLUME = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER = 1'b1;

    localparam logic [VOL_W-1:0]  VOLUME_RESET = 4'd9;
    localparam logic [CODE_W-1:0] CENTER_RESET = 10'd512;

    typedef struct packed {
        logic              start;
        logic [AMP_W-1:0]  dividend;
        logic [DIV_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [AMP_W-1:0]  quotient;
    } div_rsp_t;

    // Clamp the volume level to 1..MAX_LEVEL; the divisor is the headroom, never 0
    function automatic logic [DIV_W-1:0] divisor_of(input logic [VOL_W-1:0] level);
        logic [VOL_W-1:0] lvl;
        logic [DIV_W-1:0] d;
        lvl = level;
        if (level > VOL_W'(MAX_LEVEL))
        begin
            lvl = VOL_W'(MAX_LEVEL);
        end
        if (level == '0)
        begin
            lvl = VOL_W'(1);
        end
        d = DIV_W'(VOL_W'(MAX_LEVEL) - lvl);
        if (d == '0)
        begin
            d = DIV_W'(1);
        end
        return d;
    endfunction

endpackage

// File: sv/pcmdac_ifs.sv
// Valid/ready channel interfaces of the PCM to DAC player
interface pcmdac_req_if;
    logic                               valid;
    logic                               ready;
    logic [pcmdac_pkg::REQ_W-1:0]       req_type;
    logic [pcmdac_pkg::SAMPLE_W-1:0]    sample_word;

    modport source (output valid, output req_type, output sample_word, input ready);
    modport sink   (input valid, input req_type, input sample_word, output ready);
endinterface

interface pcmdac_dac_if;
    logic                               valid;
    logic                               ready;
    logic [pcmdac_pkg::CODE_W-1:0]      dac_main;
    logic [pcmdac_pkg::CODE_W-1:0]      dac_inverted;
    logic                               refill_request;

    modport source (output valid, output dac_main, output dac_inverted,
                    output refill_request, input ready);
    modport sink   (input valid, input dac_main, input dac_inverted,
                    input refill_request, output ready);
endinterface

// File: sv/pcmdac_div.sv
// Bit-serial restoring divider for the sample amplitude
`include "pcm_to_dac_pingpong_player_unit_defines.svh"

module pcmdac_div
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  pcmdac_pkg::div_req_t  req,
    output pcmdac_pkg::div_rsp_t  rsp
);

    logic                               busy_reg, busy_next;
    logic                               done_reg, done_next;
    logic [pcmdac_pkg::DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [pcmdac_pkg::AMP_W-1:0]       quo_reg, quo_next;
    logic [pcmdac_pkg::DIV_W-1:0]       rem_reg, rem_next;
    logic [pcmdac_pkg::DIV_W-1:0]       divisor_reg, divisor_next;
    logic [pcmdac_pkg::DIV_W:0]         trial;
    logic                               fits;

    // one quotient bit per cycle, dividend shifts out of the top of quo_reg
    assign trial = {rem_reg, quo_reg[pcmdac_pkg::AMP_W-1]};
    assign fits  = trial >= {1'b0, divisor_reg};

    always_comb
    begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        cnt_next     = cnt_reg;
        quo_next     = quo_reg;
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        if (req.start)
        begin
            busy_next    = 1'b1;
            cnt_next     = '0;
            quo_next     = req.dividend;
            rem_next     = '0;
            divisor_next = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? pcmdac_pkg::DIV_W'(trial - {1'b0, divisor_reg})
                            : trial[pcmdac_pkg::DIV_W-1:0];
            quo_next = {quo_reg[pcmdac_pkg::AMP_W-2:0], fits};
            cnt_next = cnt_reg + pcmdac_pkg::DIV_CNT_W'(1);
            if (cnt_reg == pcmdac_pkg::DIV_CNT_W'(pcmdac_pkg::AMP_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

    `PDP_ASSERT_NOW(a_div_no_restart, busy_reg, !req.start, "divider restarted while busy")
    `PDP_ASSERT_NEXT(a_div_done_idle, done_reg, !busy_reg && !done_reg, "done not a single pulse")
    `PDP_ASSERT_NOW(a_div_rem_range, busy_reg, rem_reg < divisor_reg, "partial remainder too large")

endmodule

// File: sv/pcm_to_dac_pingpong_player_unit.sv
// Top level of the two-bank PCM to DAC sample player
//
//  channel  | dir | carries                                   | transfer when
//  ---------+-----+-------------------------------------------+---------------------
//  req      | in  | req_type, sample_word                     | req.valid & req.ready
//  dac      | out | dac_main, dac_inverted, refill_request    | dac.valid & dac.ready
//  cfg      | in  | cfg_we, cfg_index, cfg_data (write only)  | cfg_we high
//
// A sample word passes through the transfer, the bit-serial divider (one quotient
// bit per cycle) and a write to the sample store. A tick is the transfer, then a
// registered read of the store; a stop loads its result at the transfer unless a result waits.
// Reset clears control state only; the sample store is not cleared.
// The output register frees the input side: a new request is taken while a
// result waits, and only a tick or stop that finds the result still waiting stalls.
`include "pcm_to_dac_pingpong_player_unit_defines.svh"

module pcm_to_dac_pingpong_player_unit
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [pcmdac_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pcmdac_pkg::CFG_DATA_W-1:0]   cfg_data,
    pcmdac_req_if.sink                          req,
    pcmdac_dac_if.source                        dac
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_READ,
        ST_STOP
    } state_t;

    state_t                                 state_reg, state_next;
    logic [pcmdac_pkg::VOL_W-1:0]           volume_reg, volume_next;
    logic [pcmdac_pkg::CODE_W-1:0]          center_reg, center_next;
    logic [pcmdac_pkg::IDX_W-1:0]           read_index_reg, read_index_next;
    logic [pcmdac_pkg::IDX_W-1:0]           write_index_reg, write_index_next;
    logic                                   read_bank_reg, read_bank_next;
    logic                                   write_bank_reg, write_bank_next;
    logic                                   negative_reg, negative_next;
    logic                                   refill_pend_reg, refill_pend_next;
    logic                                   out_valid_reg, out_valid_next;
    logic [pcmdac_pkg::CODE_W-1:0]          dac_main_reg, dac_main_next;
    logic [pcmdac_pkg::CODE_W-1:0]          dac_inv_reg, dac_inv_next;
    logic                                   refill_reg, refill_next;

    // sample store: both banks in one memory, bank 1 above bank 0
    logic [pcmdac_pkg::CODE_W-1:0]          store_mem [pcmdac_pkg::STORE_DEPTH];
    logic [pcmdac_pkg::CODE_W-1:0]          rd_data_reg;
    logic                                   mem_we;
    logic [pcmdac_pkg::ADDR_W-1:0]          wr_addr;
    logic                                   mem_re;
    logic [pcmdac_pkg::ADDR_W-1:0]          rd_addr;

    pcmdac_pkg::div_req_t                   div_req;
    pcmdac_pkg::div_rsp_t                   div_rsp;

    logic                                   accept;
    logic                                   out_free;
    logic                                   ri_wrap;
    logic [pcmdac_pkg::IDX_W-1:0]           ri_eff;
    logic                                   rb_eff;
    logic [pcmdac_pkg::IDX_W-1:0]           wi_inc;
    logic [pcmdac_pkg::CODE_W:0]            sum_up;
    logic [pcmdac_pkg::CODE_W:0]            diff_down;
    logic [pcmdac_pkg::CODE_W-1:0]          code;

    pcmdac_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;
    // output slot is free when empty or being taken this cycle
    assign out_free  = !out_valid_reg || dac.ready;

    // tick: wrap the read index past the bank end and flip the read bank
    assign ri_wrap = read_index_reg >= pcmdac_pkg::IDX_W'(pcmdac_pkg::BLOCK_SAMPLES);
    assign ri_eff  = ri_wrap ? '0 : read_index_reg;
    assign rb_eff  = read_bank_reg ^ ri_wrap;
    assign rd_addr = rb_eff ? pcmdac_pkg::ADDR_W'(pcmdac_pkg::BLOCK_SAMPLES)
                              + pcmdac_pkg::ADDR_W'(ri_eff)
                            : pcmdac_pkg::ADDR_W'(ri_eff);
    assign wr_addr = write_bank_reg ? pcmdac_pkg::ADDR_W'(pcmdac_pkg::BLOCK_SAMPLES)
                                      + pcmdac_pkg::ADDR_W'(write_index_reg)
                                    : pcmdac_pkg::ADDR_W'(write_index_reg);
    assign wi_inc  = write_index_reg + pcmdac_pkg::IDX_W'(1);

    // drop the low bits of the word (or of its one's complement when negative)
    assign div_req.start    = accept && (req.req_type == pcmdac_pkg::REQ_SAMPLE);
    assign div_req.dividend = req.sample_word[pcmdac_pkg::SAMPLE_W-1]
                            ? ~req.sample_word[pcmdac_pkg::SAMPLE_W-1:pcmdac_pkg::DROP_BITS]
                            : req.sample_word[pcmdac_pkg::SAMPLE_W-1:pcmdac_pkg::DROP_BITS];
    assign div_req.divisor  = pcmdac_pkg::divisor_of(volume_reg);

    // offset from centre with saturation at both rails
    assign sum_up    = (pcmdac_pkg::CODE_W+1)'(center_reg)
                     + (pcmdac_pkg::CODE_W+1)'(div_rsp.quotient);
    assign diff_down = (pcmdac_pkg::CODE_W+1)'(center_reg)
                     - (pcmdac_pkg::CODE_W+1)'(div_rsp.quotient);
    always_comb
    begin
        if (negative_reg)
        begin
            code = diff_down[pcmdac_pkg::CODE_W] ? '0 : diff_down[pcmdac_pkg::CODE_W-1:0];
        end
        else
        begin
            code = sum_up[pcmdac_pkg::CODE_W] ? pcmdac_pkg::DAC_MAX
                                               : sum_up[pcmdac_pkg::CODE_W-1:0];
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        volume_next      = volume_reg;
        center_next      = center_reg;
        read_index_next  = read_index_reg;
        write_index_next = write_index_reg;
        read_bank_next   = read_bank_reg;
        write_bank_next  = write_bank_reg;
        negative_next    = negative_reg;
        refill_pend_next = refill_pend_reg;
        out_valid_next   = out_valid_reg && !dac.ready;
        dac_main_next    = dac_main_reg;
        dac_inv_next     = dac_inv_reg;
        refill_next      = refill_reg;
        mem_we           = 1'b0;
        mem_re           = 1'b0;

        if (cfg_we)
        begin
            case (cfg_index)
                pcmdac_pkg::CFG_VOLUME: volume_next = cfg_data[pcmdac_pkg::VOL_W-1:0];
                pcmdac_pkg::CFG_CENTER: center_next = cfg_data[pcmdac_pkg::CODE_W-1:0];
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (req.req_type)
                        pcmdac_pkg::REQ_SAMPLE:
                        begin
                            negative_next = req.sample_word[pcmdac_pkg::SAMPLE_W-1];
                            state_next    = ST_DIV;
                        end
                        pcmdac_pkg::REQ_TICK:
                        begin
                            // refill when the read side reaches the switch point
                            mem_re           = 1'b1;
                            read_bank_next   = rb_eff;
                            read_index_next  = ri_eff + pcmdac_pkg::IDX_W'(1);
                            refill_pend_next =
                                (ri_eff == pcmdac_pkg::IDX_W'(pcmdac_pkg::SWITCH_POINT));
                            if (refill_pend_next)
                            begin
                                write_bank_next = !write_bank_reg;
                            end
                            state_next = ST_READ;
                        end
                        pcmdac_pkg::REQ_STOP:
                        begin
                            read_index_next  = '0;
                            write_index_next = '0;
                            read_bank_next   = 1'b0;
                            write_bank_next  = 1'b0;
                            if (out_free)
                            begin
                                out_valid_next = 1'b1;
                                dac_main_next  = center_reg;
                                dac_inv_next   = center_reg;
                                refill_next    = 1'b0;
                            end
                            else
                            begin
                                state_next = ST_STOP;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_DIV:
            begin
                // store the code and advance, wrapping at the bank end
                if (div_rsp.done)
                begin
                    mem_we = 1'b1;
                    write_index_next = (wi_inc >= pcmdac_pkg::IDX_W'(pcmdac_pkg::BLOCK_SAMPLES))
                                     ? '0 : wi_inc;
                    state_next = ST_IDLE;
                end
            end
            ST_READ:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    dac_main_next  = rd_data_reg;
                    dac_inv_next   = pcmdac_pkg::DAC_MAX - rd_data_reg;
                    refill_next    = refill_pend_reg;
                    state_next     = ST_IDLE;
                end
            end
            ST_STOP:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    dac_main_next  = center_reg;
                    dac_inv_next   = center_reg;
                    refill_next    = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            volume_reg      <= pcmdac_pkg::VOLUME_RESET;
            center_reg      <= pcmdac_pkg::CENTER_RESET;
            read_index_reg  <= '0;
            write_index_reg <= '0;
            read_bank_reg   <= 1'b0;
            write_bank_reg  <= 1'b0;
            negative_reg    <= 1'b0;
            refill_pend_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            dac_main_reg    <= '0;
            dac_inv_reg     <= '0;
            refill_reg      <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            volume_reg      <= volume_next;
            center_reg      <= center_next;
            read_index_reg  <= read_index_next;
            write_index_reg <= write_index_next;
            read_bank_reg   <= read_bank_next;
            write_bank_reg  <= write_bank_next;
            negative_reg    <= negative_next;
            refill_pend_reg <= refill_pend_next;
            out_valid_reg   <= out_valid_next;
            dac_main_reg    <= dac_main_next;
            dac_inv_reg     <= dac_inv_next;
            refill_reg      <= refill_next;
        end
    end

    // sample store: one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[wr_addr] <= code;
        end
        if (mem_re)
        begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    assign dac.valid          = out_valid_reg;
    assign dac.dac_main       = dac_main_reg;
    assign dac.dac_inverted   = dac_inv_reg;
    assign dac.refill_request = refill_reg;

    `PDP_ASSERT_NOW(a_read_index_range, 1'b1,
        read_index_reg <= pcmdac_pkg::IDX_W'(pcmdac_pkg::BLOCK_SAMPLES),
        "read index past bank end")
    `PDP_ASSERT_NOW(a_write_index_range, 1'b1,
        write_index_reg < pcmdac_pkg::IDX_W'(pcmdac_pkg::BLOCK_SAMPLES),
        "write index past bank end")
    `PDP_ASSERT_NOW(a_done_in_div, div_rsp.done, state_reg == ST_DIV,
        "divider finished outside a sample")
    `PDP_ASSERT_NOW(a_refill_pair, out_valid_reg && refill_reg,
        dac_inv_reg == pcmdac_pkg::DAC_MAX - dac_main_reg, "refill result not a tick pair")

endmodule

// File: tb/pcm_to_dac_pingpong_player_unit_checker.sv
// Scoreboard of the PCM to DAC player: predicts and compares each result transfer
module pcm_to_dac_pingpong_player_unit_checker
    import pcmdac_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    pcmdac_req_if                 req,
    pcmdac_dac_if                 dac,
    output int                    fail_count,
    output int                    pending,
    output logic                  tick_safe
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [CODE_W-1:0] main;
        logic [CODE_W-1:0] inverted;
        logic              refill;
    } dac_word_t;

    dac_word_t         dac_codes_due[$];
    logic [CODE_W-1:0] code_store [STORE_DEPTH];
    bit                stored [STORE_DEPTH];
    int                rd_idx;
    int                wr_idx;
    logic              rd_bank;
    logic              wr_bank;
    logic [VOL_W-1:0]  volume;
    logic [CODE_W-1:0] centre;

    // Scale a PCM word down to a DAC code around the centre, saturating at both rails
    function automatic logic [CODE_W-1:0] pcm_to_code(input logic [SAMPLE_W-1:0] word,
                                                      input logic [VOL_W-1:0] level,
                                                      input logic [CODE_W-1:0] mid);
        int               lvl;
        int               div;
        int               amp;
        int               sum;
        logic [SAMPLE_W-1:0] mag;
        lvl = int'(level);
        if (lvl > MAX_LEVEL)
        begin
            lvl = MAX_LEVEL;
        end
        if (lvl < 1)
        begin
            lvl = 1;
        end
        div = MAX_LEVEL - lvl;
        if (div == 0)
        begin
            div = 1;
        end
        mag = word[SAMPLE_W-1] ? ~word : word;
        amp = int'(mag >> DROP_BITS) / div;
        if (word[SAMPLE_W-1])
        begin
            return (amp > int'(mid)) ? '0 : CODE_W'(int'(mid) - amp);
        end
        sum = int'(mid) + amp;
        return (sum > int'(DAC_MAX)) ? DAC_MAX : CODE_W'(sum);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track_player
        dac_word_t want;
        dac_word_t got;
        int        slot;
        logic      bank;
        if (!rst_n)
        begin
            rd_idx     = 0;
            wr_idx     = 0;
            rd_bank    = 1'b0;
            wr_bank    = 1'b0;
            volume     = VOLUME_RESET;
            centre     = CENTER_RESET;
            fail_count = 0;
            dac_codes_due.delete();
            for (int i = 0; i < STORE_DEPTH; i++)
            begin
                stored[i] = 1'b0;
            end
        end
        else
        begin
            if (dac.valid && dac.ready)
            begin
                got = {dac.dac_main, dac.dac_inverted, dac.refill_request};
                if (dac_codes_due.size() == 0)
                begin
                    $display("%0t: unexpected result main=%0d inverted=%0d refill=%0b",
                             $time, got.main, got.inverted, got.refill);
                    fail_count++;
                end
                else
                begin
                    want = dac_codes_due.pop_front();
                    if (got.main !== want.main || got.inverted !== want.inverted ||
                        got.refill !== want.refill)
                    begin
                        $display("%0t: expected %0d/%0d/%0b, actual %0d/%0d/%0b",
                                 $time, want.main, want.inverted, want.refill,
                                 got.main, got.inverted, got.refill);
                        fail_count++;
                    end
                end
            end

            if (cfg_we)
            begin
                if (cfg_index == CFG_VOLUME)
                begin
                    volume = cfg_data[VOL_W-1:0];
                end
                else if (cfg_index == CFG_CENTER)
                begin
                    centre = cfg_data;
                end
            end

            if (req.valid && req.ready)
            begin
                case (req.req_type)
                    REQ_SAMPLE:
                    begin
                        if (wr_idx >= BLOCK_SAMPLES)
                        begin
                            wr_idx = 0;
                        end
                        slot = int'(wr_bank) * BLOCK_SAMPLES + wr_idx;
                        code_store[slot] = pcm_to_code(req.sample_word, volume, centre);
                        stored[slot] = 1'b1;
                        wr_idx = (wr_idx + 1 >= BLOCK_SAMPLES) ? 0 : wr_idx + 1;
                    end
                    REQ_TICK:
                    begin
                        if (rd_idx >= BLOCK_SAMPLES)
                        begin
                            rd_idx  = 0;
                            rd_bank = ~rd_bank;
                        end
                        want.refill = (rd_idx == SWITCH_POINT);
                        if (want.refill)
                        begin
                            wr_bank = ~wr_bank;
                        end
                        want.main     = code_store[int'(rd_bank) * BLOCK_SAMPLES + rd_idx];
                        want.inverted = DAC_MAX - want.main;
                        rd_idx++;
                        dac_codes_due.push_back(want);
                    end
                    REQ_STOP:
                    begin
                        rd_idx  = 0;
                        wr_idx  = 0;
                        rd_bank = 1'b0;
                        wr_bank = 1'b0;
                        want    = {centre, centre, 1'b0};
                        dac_codes_due.push_back(want);
                    end
                    default:
                    begin
                    end
                endcase
            end
        end

        pending = dac_codes_due.size();
        // a tick is only legal when the slot it will read has been written
        bank = rd_bank;
        slot = rd_idx;
        if (slot >= BLOCK_SAMPLES)
        begin
            slot = 0;
            bank = ~bank;
        end
        tick_safe = stored[int'(bank) * BLOCK_SAMPLES + slot];
    end

endmodule

// File: tb/pcm_to_dac_pingpong_player_unit_tb.sv
// Top of the PCM to DAC player testbench: clock, reset, stimulus and verdict
module pcm_to_dac_pingpong_player_unit_tb
    import pcmdac_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    // request code the block must ignore
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    // a sample word must finish inside the block; wait longer than it needs
    localparam int SETTLE_CYCLES = 20;
    localparam int PHASE_ITEMS   = 96;
    localparam int PHASES        = 6;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // percentage of cycles in which the sender idles and the receiver stalls
    int   idle_pct;
    int   stall_pct;

    int   fail_count;
    int   pending;
    logic tick_safe;

    pcmdac_req_if req_ch ();
    pcmdac_dac_if dac_ch ();

    pcm_to_dac_pingpong_player_unit DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .dac       (dac_ch)
    );

    pcm_to_dac_pingpong_player_unit_checker scoreboard
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .req        (req_ch),
        .dac        (dac_ch),
        .fail_count (fail_count),
        .pending    (pending),
        .tick_safe  (tick_safe)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #1 clk = ~clk;
        end
    end

    // Drop ready at random on the receiving side; with stall_pct at 0 it holds high
    always @(negedge clk)
    begin
        dac_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Guard against a hung handshake: far beyond the slowest legal run
    initial
    begin
        #1_000_000;
        $display("FAIL pcm_to_dac_pingpong_player_unit");
        $finish;
    end

    // Offer one request from a falling edge and hold it until its transfer.
    // Returns on the falling edge after the transfer, with valid still high,
    // so a following request that does not idle keeps valid up without a dip.
    task automatic send_item(input logic [REQ_W-1:0] kind, input logic [SAMPLE_W-1:0] word);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.req_type    <= kind;
        req_ch.sample_word <= word;
        @(posedge clk);
        while (!req_ch.ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    // Hold the sender off until every result has come, then let any sample
    // still in the divider finish before the block is treated as idle
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Write both registers on consecutive edges; the padding above the volume
    // field is random so that every data bit toggles
    task automatic set_config(input logic [VOL_W-1:0] vol, input logic [CODE_W-1:0] mid);
        logic [CFG_DATA_W-VOL_W-1:0] pad;
        pad = (CFG_DATA_W-VOL_W)'($urandom);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_VOLUME;
        cfg_data  <= {pad, vol};
        @(negedge clk);
        cfg_index <= CFG_CENTER;
        cfg_data  <= mid;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Mostly uniform words, with the rails and the first step past the
    // dropped bits mixed in now and then
    function automatic logic [SAMPLE_W-1:0] random_word();
        if ($urandom_range(0, 7) == 0)
        begin
            case ($urandom_range(0, 5))
                0:       return 16'h0000;
                1:       return 16'h7FFF;
                2:       return 16'h8000;
                3:       return 16'hFFFF;
                4:       return 16'h0040;
                default: return 16'hFFBF;
            endcase
        end
        return SAMPLE_W'($urandom);
    endfunction

    // Pick one random request. Ticks only go out when the slot they read
    // holds a written code; otherwise send a sample to fill the bank.
    // Stops are rare so that playback reaches the bank switch and beyond.
    task automatic random_item(output bit counted);
        int pick;
        pick    = $urandom_range(0, 999);
        counted = 1'b1;
        if (pick < 5)
        begin
            send_item(REQ_STOP, random_word());
        end
        else if (pick < 35)
        begin
            send_item(REQ_UNUSED, random_word());
            counted = 1'b0;
        end
        else if (pick < 515 && tick_safe)
        begin
            send_item(REQ_TICK, random_word());
        end
        else
        begin
            send_item(REQ_SAMPLE, random_word());
        end
    endtask

    initial
    begin : stimulus
        int               sent;
        bit               counted;
        logic [VOL_W-1:0]  vol;
        logic [CODE_W-1:0] mid;

        // drive every input to a known value from time zero
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = CFG_VOLUME;
        cfg_data           = '0;
        req_ch.valid       = 1'b0;
        req_ch.req_type    = REQ_SAMPLE;
        req_ch.sample_word = '0;
        dac_ch.ready       = 1'b0;
        idle_pct           = 0;
        stall_pct          = 0;

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed, reset settings: zero, both rails, minus zero and one step
        // either side of centre, played back in order; then an ignored code
        // and a stop
        send_item(REQ_SAMPLE, 16'h0000);
        send_item(REQ_SAMPLE, 16'h7FFF);
        send_item(REQ_SAMPLE, 16'h8000);
        send_item(REQ_SAMPLE, 16'hFFFF);
        send_item(REQ_SAMPLE, 16'h0040);
        send_item(REQ_SAMPLE, 16'hFFBF);
        repeat (6) send_item(REQ_TICK, 16'h5A5A);
        send_item(REQ_UNUSED, 16'hA5A5);
        send_item(REQ_STOP, 16'h0000);

        // Level above the top is clamped to the top, divisor of zero taken
        // as one; a high centre makes the positive side saturate
        drain_results();
        set_config(4'd15, 10'd1000);
        send_item(REQ_SAMPLE, 16'h7FFF);
        send_item(REQ_SAMPLE, 16'h0000);

        // Level zero is taken as one; a low centre makes the negative side
        // saturate at zero
        drain_results();
        set_config(4'd0, 10'd20);
        send_item(REQ_SAMPLE, 16'h8000);
        send_item(REQ_SAMPLE, 16'hFFFF);
        repeat (4) send_item(REQ_TICK, 16'hFFFF);
        send_item(REQ_STOP, 16'hFFFF);

        // Random phases, each with its own register settings and idling mix
        for (int phase = 0; phase < PHASES; phase++)
        begin
            drain_results();
            case (phase)
                0:
                begin
                    vol = 4'd5;  mid = 10'd512;  idle_pct = 0;  stall_pct = 0;
                end
                1:
                begin
                    vol = 4'd10; mid = 10'd0;    idle_pct = 74; stall_pct = 0;
                end
                2:
                begin
                    vol = 4'd1;  mid = 10'd1023; idle_pct = 0;  stall_pct = 74;
                end
                3:
                begin
                    vol = 4'd0;  mid = CODE_W'($urandom); idle_pct = 15; stall_pct = 15;
                end
                4:
                begin
                    vol = 4'd15; mid = CODE_W'($urandom); idle_pct = 0;  stall_pct = 0;
                end
                default:
                begin
                    vol = VOL_W'($urandom); mid = CODE_W'($urandom);
                    idle_pct = 40; stall_pct = 40;
                end
            endcase
            set_config(vol, mid);
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                random_item(counted);
                sent += int'(counted);
                // now and then hold the sender until the results have caught up
                if ($urandom_range(0, 99) == 0)
                begin
                    drain_results();
                end
            end
        end

        drain_results();
        if (fail_count == 0)
        begin
            $display("PASS pcm_to_dac_pingpong_player_unit");
        end
        else
        begin
            $display("FAIL pcm_to_dac_pingpong_player_unit");
        end
        $finish;
    end

endmodule
